// ----- design/tga_rle_pixel_decoder_unit_defines.svh -----
// Assertion macros for the TGA run-length pixel decoder.
// Included by the checker; no other dependencies.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TRPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define TRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- design/trpd_pkg.sv -----
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies.
`default_nettype none
package trpd_pkg;

	localparam int CFG_W   = 15;
	localparam int LEFT_W  = 30;
	localparam int COLOR_W = 8;
	localparam int LEN_W   = 8;
	localparam int OUT_W   = 15;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int RUN_BIT = 7;

	typedef struct packed {
		logic take_byte;
		logic load_span;
		logic wrap_step;
		logic wrap_finish;
	} trpd_cmd_t;

	typedef struct packed {
		logic emit_byte;
		logic wrap_done;
	} trpd_status_t;

endpackage
`default_nettype wire

// ----- design/tga_rle_pixel_decoder_unit.sv -----
// Top level of the TGA run-length pixel decoder: controller, datapath
// and APB configuration port. Depends on trpd_pkg, trpd_ctrl, trpd_datapath.
//
// Usage:
//   Byte channel (data_byte, first_byte; byte_valid/byte_stall) takes the
//   pixel-data bytes of a run-length-coded 32-bit BGRA image. first_byte
//   marks the first header and restarts placement at column 0 of the
//   bottom-stored top row. Span channel (span_valid/span_stall) returns one
//   span per run packet or raw pixel, on its alpha byte.
//   Header and colour bytes are taken while idle. An alpha byte is followed
//   by the emit state, which loads the span once the output slot is free,
//   and the wrap state, which makes W = (column + length) / width row wraps;
//   the wrap loop subtracts the width once per cycle.
//   Reset sets width and height to 1 and clears all packet and position
//   state; no span is pending.
//   A stalled span holds in the output register; the next bytes are still
//   taken until another span must be loaded, which then waits for the slot.
//   image_width (0x0) and image_height (0x4) must be written only when idle; the block does not enforce this.
`default_nettype none
module tga_rle_pixel_decoder_unit
	import trpd_pkg::*;
#(
	parameter int COORD_BITS = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              first_byte,
	output logic                   span_valid,
	input  wire logic              span_stall,
	output logic [OUT_W-1:0]       start_row,
	output logic [OUT_W-1:0]       start_column,
	output logic [LEN_W-1:0]       run_length,
	output logic [COLOR_W-1:0]     red,
	output logic [COLOR_W-1:0]     green,
	output logic [COLOR_W-1:0]     blue,
	output logic                   pixels_dropped
);

	trpd_cmd_t    cmd;
	trpd_status_t status;

	assign pready = 1'b1;

	trpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.status     (status),
		.cmd        (cmd)
	);

	trpd_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.cmd            (cmd),
		.status         (status),
		.start_row      (start_row),
		.start_column   (start_column),
		.run_length     (run_length),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.pixels_dropped (pixels_dropped)
	);

endmodule
`default_nettype wire

// ----- design/trpd_ctrl.sv -----
// Controller of the TGA run-length pixel decoder: sequences byte intake,
// span loading and column wrap steps. Depends on trpd_pkg.
`default_nettype none
module trpd_ctrl
	import trpd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	output logic              byte_stall,
	output logic              span_valid,
	input  wire logic         span_stall,
	input  wire trpd_status_t status,
	output trpd_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_WRAP
	} state_t;

	state_t state_q;
	logic   span_valid_q;
	logic   slot_free;

	assign slot_free  = !span_valid_q || !span_stall;
	assign byte_stall = (state_q != ST_IDLE);
	assign span_valid = span_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.take_byte = byte_valid;
			ST_EMIT: cmd.load_span = slot_free;
			ST_WRAP: begin
				cmd.wrap_step   = !status.wrap_done;
				cmd.wrap_finish = status.wrap_done;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			span_valid_q <= 1'b0;
		end else begin
			if (cmd.load_span)
				span_valid_q <= 1'b1;
			else if (span_valid_q && !span_stall)
				span_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (byte_valid && status.emit_byte)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free)
						state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (status.wrap_done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/trpd_datapath.sv -----
// Datapath of the TGA run-length pixel decoder: configuration registers,
// packet and position state, span output registers. Depends on trpd_pkg.
`default_nettype none
module trpd_datapath
	import trpd_pkg::*;
#(
	parameter int COORD_BITS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]        prdata,
	input  wire logic [7:0]          data_byte,
	input  wire logic                first_byte,
	input  wire trpd_cmd_t           cmd,
	output trpd_status_t             status,
	output logic [OUT_W-1:0]         start_row,
	output logic [OUT_W-1:0]         start_column,
	output logic [LEN_W-1:0]         run_length,
	output logic [COLOR_W-1:0]       red,
	output logic [COLOR_W-1:0]       green,
	output logic [COLOR_W-1:0]       blue,
	output logic                     pixels_dropped
);

	localparam int RW = COORD_BITS + 1;
	localparam int PW = (RW > CFG_W) ? RW : CFG_W;

	typedef enum logic [1:0] {
		BYTE_BLUE,
		BYTE_GREEN,
		BYTE_RED,
		BYTE_ALPHA
	} byte_pos_t;

	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic                  in_packet_q;
	logic                  packet_is_run_q;
	logic [LEN_W-1:0]      pix_left_q;
	byte_pos_t             byte_pos_q;
	logic [COLOR_W-1:0]    blue_q;
	logic [COLOR_W-1:0]    green_q;
	logic [COLOR_W-1:0]    red_q;
	logic [COORD_BITS-1:0] column_q;
	logic [RW-1:0]         row_q;
	logic [LEFT_W-1:0]     left_q;
	logic [PW-1:0]         pos_q;

	logic [CFG_W-1:0]      eff_w;
	logic [CFG_W-1:0]      eff_h;
	logic [LEFT_W-1:0]     total_pixels;
	logic [PW-1:0]         top_row;
	logic                  header;
	logic [LEN_W-1:0]      want;
	logic [LEN_W-1:0]      span_len;
	logic                  span_drop;
	logic [PW-1:0]         pos_next;
	logic [PW-1:0]         row_ext;
	logic [PW-1:0]         col_ext;
	logic                  cfg_write;

	assign cfg_write    = psel && penable && pwrite;
	assign prdata       = (paddr[2] == REG_WIDTH) ? APB_DW'(width_q) : APB_DW'(height_q);

	assign eff_w        = (width_q == '0) ? CFG_W'(1) : width_q;
	assign eff_h        = (height_q == '0) ? CFG_W'(1) : height_q;
	assign total_pixels = LEFT_W'(eff_w) * LEFT_W'(eff_h);
	assign top_row      = PW'(eff_h - CFG_W'(1));
	assign header       = first_byte || !in_packet_q;

	assign want         = packet_is_run_q ? pix_left_q : LEN_W'(1);
	assign span_drop    = LEFT_W'(want) > left_q;
	assign span_len     = span_drop ? left_q[LEN_W-1:0] : want;
	assign pos_next     = PW'(column_q) + PW'(span_len);
	assign row_ext      = PW'(row_q);
	assign col_ext      = PW'(column_q);

	assign status.emit_byte = !first_byte && in_packet_q && (byte_pos_q == BYTE_ALPHA);
	assign status.wrap_done = pos_q < PW'(eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_write) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q     <= 1'b0;
			packet_is_run_q <= 1'b0;
			pix_left_q      <= '0;
			byte_pos_q      <= BYTE_BLUE;
			blue_q          <= '0;
			green_q         <= '0;
			red_q           <= '0;
			column_q        <= '0;
			row_q           <= '0;
			left_q          <= '0;
		end else begin
			if (cmd.take_byte) begin
				if (first_byte) begin
					column_q <= '0;
					row_q    <= top_row[RW-1:0];
					left_q   <= total_pixels;
				end
				if (header) begin
					packet_is_run_q <= data_byte[RUN_BIT];
					pix_left_q      <= {1'b0, data_byte[RUN_BIT-1:0]} + LEN_W'(1);
					byte_pos_q      <= BYTE_BLUE;
					in_packet_q     <= 1'b1;
				end else begin
					case (byte_pos_q)
						BYTE_BLUE: begin
							blue_q     <= data_byte;
							byte_pos_q <= BYTE_GREEN;
						end
						BYTE_GREEN: begin
							green_q    <= data_byte;
							byte_pos_q <= BYTE_RED;
						end
						BYTE_RED: begin
							red_q      <= data_byte;
							byte_pos_q <= BYTE_ALPHA;
						end
						default: byte_pos_q <= BYTE_BLUE;
					endcase
				end
			end
			if (cmd.load_span) begin
				left_q <= left_q - LEFT_W'(span_len);
				if (packet_is_run_q) begin
					pix_left_q  <= '0;
					in_packet_q <= 1'b0;
				end else begin
					pix_left_q <= pix_left_q - LEN_W'(1);
					if (pix_left_q == LEN_W'(1))
						in_packet_q <= 1'b0;
				end
			end
			if (cmd.wrap_step)
				row_q <= row_q - RW'(1);
			if (cmd.wrap_finish)
				column_q <= pos_q[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_span) begin
			pos_q          <= pos_next;
			start_row      <= row_ext[OUT_W-1:0];
			start_column   <= col_ext[OUT_W-1:0];
			run_length     <= span_len;
			red            <= red_q;
			green          <= green_q;
			blue           <= blue_q;
			pixels_dropped <= span_drop;
		end else if (cmd.wrap_step) begin
			pos_q <= pos_q - PW'(eff_w);
		end
	end

endmodule
`default_nettype wire

// ----- design/trpd_checker.sv -----
// Port-level checker for the TGA run-length pixel decoder, bound to the top.
// Depends on trpd_pkg and tga_rle_pixel_decoder_unit_defines.svh.
`default_nettype none
`include "tga_rle_pixel_decoder_unit_defines.svh"
module trpd_checker
	import trpd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               pready,
	input wire logic               byte_stall,
	input wire logic               span_valid,
	input wire logic               span_stall,
	input wire logic [OUT_W-1:0]   start_row,
	input wire logic [OUT_W-1:0]   start_column,
	input wire logic [LEN_W-1:0]   run_length,
	input wire logic [COLOR_W-1:0] red,
	input wire logic [COLOR_W-1:0] green,
	input wire logic [COLOR_W-1:0] blue,
	input wire logic               pixels_dropped
);

	logic                               span_held;
	logic [2*OUT_W+LEN_W+3*COLOR_W:0] span_bus;

	assign span_held = span_valid && span_stall;
	assign span_bus  = {start_row, start_column, run_length, red, green, blue, pixels_dropped};

	`TRPD_ASSERT_NEXT(a_span_hold, clk, arst_n, span_held, span_valid && $stable(span_bus))
	`TRPD_ASSERT_IMPLY(a_len_max, clk, arst_n, span_valid, run_length <= LEN_W'(128))
	`TRPD_ASSERT_IMPLY(a_len_nonzero, clk, arst_n, span_valid && !pixels_dropped, |run_length)
	`TRPD_ASSERT_IMPLY(a_span_while_busy, clk, arst_n, $rose(span_valid), byte_stall)
	`TRPD_ASSERT_IMPLY(a_pready, clk, arst_n, psel, pready)

endmodule

bind tga_rle_pixel_decoder_unit trpd_checker u_trpd_checker (.*);
`default_nettype wire

// ----- sim/trpd_span_checker.sv -----
// Span checker for the TGA run-length pixel decoder: follows register writes and byte
// transactions, predicts every span and compares it with the span channel.
// Depends on trpd_pkg.
module trpd_span_checker
	import trpd_pkg::*;
#(
	parameter int COORD_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               pready,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               span_valid,
	input  logic               span_stall,
	input  logic [OUT_W-1:0]   start_row,
	input  logic [OUT_W-1:0]   start_column,
	input  logic [LEN_W-1:0]   run_length,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	input  logic               pixels_dropped,
	output int unsigned        err_count,
	output int unsigned        pending
);

	typedef struct packed {
		logic [OUT_W-1:0]   row;
		logic [OUT_W-1:0]   column;
		logic [LEN_W-1:0]   length;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               dropped;
	} span_t;

	span_t spans_due[$];

	logic [CFG_W-1:0]      cfg_width;
	logic [CFG_W-1:0]      cfg_height;
	logic                  pkt_open;
	logic                  pkt_run;
	logic [7:0]            pkt_left;
	logic [1:0]            byte_idx;
	logic [COLOR_W-1:0]    hold_blue;
	logic [COLOR_W-1:0]    hold_green;
	logic [COLOR_W-1:0]    hold_red;
	logic [COORD_BITS-1:0] col_pos;
	logic [COORD_BITS:0]   row_pos;
	logic [LEFT_W-1:0]     pixels_left;

	function automatic int unsigned at_least_one(input logic [CFG_W-1:0] v);
		return (v == '0) ? 1 : 32'(v);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic place_span(input int unsigned want);
		int unsigned len;
		int unsigned pos;
		int unsigned wraps;
		int unsigned w;
		span_t s;
		w = at_least_one(cfg_width);
		len = want;
		s.dropped = 1'b0;
		if (len > pixels_left) begin
			len = pixels_left;
			s.dropped = 1'b1;
		end
		s.row = OUT_W'(row_pos);
		s.column = OUT_W'(col_pos);
		s.length = LEN_W'(len);
		s.red = hold_red;
		s.green = hold_green;
		s.blue = hold_blue;
		spans_due.push_back(s);
		pixels_left = pixels_left - LEFT_W'(len);
		pos = col_pos + len;
		wraps = pos / w;
		col_pos = COORD_BITS'(pos % w);
		row_pos = row_pos - (COORD_BITS + 1)'(wraps);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic first);
		if (first) begin
			col_pos = '0;
			row_pos = (COORD_BITS + 1)'(at_least_one(cfg_height) - 1);
			pixels_left = LEFT_W'(at_least_one(cfg_width) * at_least_one(cfg_height));
			pkt_open = 1'b0;
			byte_idx = '0;
		end
		if (!pkt_open) begin
			pkt_run = b[RUN_BIT];
			pkt_left = {1'b0, b[6:0]} + 8'd1;
			byte_idx = '0;
			pkt_open = 1'b1;
		end else if (byte_idx != 2'd3) begin
			case (byte_idx)
				2'd0: hold_blue = b;
				2'd1: hold_green = b;
				default: hold_red = b;
			endcase
			byte_idx = byte_idx + 2'd1;
		end else begin
			byte_idx = '0;
			if (pkt_run) begin
				place_span(pkt_left);
				pkt_left = '0;
				pkt_open = 1'b0;
			end else begin
				place_span(1);
				pkt_left = pkt_left - 8'd1;
				if (pkt_left == '0)
					pkt_open = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_t due;
		if (!arst_n) begin
			spans_due.delete();
			cfg_width = CFG_W'(1);
			cfg_height = CFG_W'(1);
			pkt_open = 1'b0;
			pkt_run = 1'b0;
			pkt_left = '0;
			byte_idx = '0;
			hold_blue = '0;
			hold_green = '0;
			hold_red = '0;
			col_pos = '0;
			row_pos = '0;
			pixels_left = '0;
			err_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WIDTH)
					cfg_width = pwdata[CFG_W-1:0];
				else if (paddr[2] == REG_HEIGHT)
					cfg_height = pwdata[CFG_W-1:0];
			end
			if (byte_valid && !byte_stall)
				decode_byte(data_byte, first_byte);
			if (span_valid && !span_stall) begin
				if (spans_due.size() == 0) begin
					$error("span transaction with none expected: row %0d, column %0d",
						start_row, start_column);
					err_count++;
				end else begin
					due = spans_due.pop_front();
					check_field("start_row", due.row, start_row);
					check_field("start_column", due.column, start_column);
					check_field("run_length", due.length, run_length);
					check_field("red", due.red, red);
					check_field("green", due.green, green);
					check_field("blue", due.blue, blue);
					check_field("pixels_dropped", due.dropped, pixels_dropped);
				end
			end
			pending = spans_due.size();
		end
	end

endmodule

// ----- sim/tga_rle_pixel_decoder_unit_tb.sv -----
// Testbench top for the TGA run-length pixel decoder: clock, reset, register writes and
// byte stimulus under varying idle and stall pressure; verdict from trpd_span_checker.
// Depends on trpd_pkg, tga_rle_pixel_decoder_unit and trpd_span_checker.
module tga_rle_pixel_decoder_unit_tb;
	import trpd_pkg::*;

	localparam int NUM_PHASES      = 16;
	localparam int FIXED_PHASES    = 12;
	localparam int MID_IMAGE_PHASE = 6;
	localparam int PHASE_ITEMS     = 110;
	localparam int DRAIN_CYCLES    = 300;
	localparam int CYCLE_LIMIT     = 2_000_000;

	localparam logic [CFG_W-1:0] PHASE_W [FIXED_PHASES] =
		'{4, 32767, 1, 0, 7, 32767, 5, 1, 3, 16, 9, 2};
	localparam logic [CFG_W-1:0] PHASE_H [FIXED_PHASES] =
		'{3, 32767, 32767, 0, 1, 2, 4, 1, 3, 2, 32767, 5};

	localparam logic [7:0] PRE_MARK_BYTES [5] = '{8'h80, 8'h12, 8'h34, 8'h56, 8'h78};
	localparam logic [7:0] IMAGE_BYTES [19] = '{
		8'h81, 8'hFF, 8'h00, 8'hFF, 8'h00,
		8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hAA, 8'h55,
		8'hFF, 8'h01, 8'h02, 8'h03, 8'h04};

	typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [APB_AW-1:0]   paddr      = '0;
	logic [APB_DW-1:0]   pwdata     = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	logic [7:0]          data_byte  = '0;
	logic                first_byte = 1'b0;
	logic                span_valid;
	logic                span_stall = 1'b0;
	logic [OUT_W-1:0]    start_row;
	logic [OUT_W-1:0]    start_column;
	logic [LEN_W-1:0]    run_length;
	logic [COLOR_W-1:0]  red;
	logic [COLOR_W-1:0]  green;
	logic [COLOR_W-1:0]  blue;
	logic                pixels_dropped;
	int unsigned         err_count;
	int unsigned         pending;
	int unsigned         sent_bytes    = 0;
	int unsigned         send_idle_pct = 0;
	int unsigned         stall_pct     = 0;
	int unsigned         cycle_count;

	tga_rle_pixel_decoder_unit u_top (.*);

	trpd_span_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk)
		span_stall <= ($urandom_range(99) < stall_pct);

	function automatic logic [7:0] some_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
			PACE_SEND_IDLE:  begin send_idle_pct = 66; stall_pct = 0;  end
			PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 66; end
			default:         begin send_idle_pct = 8;  stall_pct = 8;  end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			data_byte <= 8'($urandom);
			first_byte <= 1'($urandom);
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		first_byte <= first;
		do begin
			@(negedge clk);
			stalled = byte_stall;
			@(posedge clk);
		end while (stalled);
		sent_bytes++;
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		logic ready;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ready = pready;
			@(posedge clk);
		end while (!ready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// hold the byte channel until every predicted span has come out
	task automatic settle(input int unsigned extra);
		byte_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0)
				break;
		end
		@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		settle(DRAIN_CYCLES);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic send_packet(input logic start);
		logic run;
		logic [6:0] count;
		int unsigned pixels;
		run = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: count = 7'h7F;
			1, 2: count = 7'($urandom_range(127));
			default: count = 7'($urandom_range(3));
		endcase
		if (!run && count > 7 && $urandom_range(7) != 0)
			count = 7'($urandom_range(7));
		pixels = run ? 1 : count + 1;
		send_byte({run, count}, start);
		for (int i = 0; i < pixels * 4; i++) begin
			// drop the open packet with a stray first-byte mark now and then
			if ($urandom_range(199) == 0) begin
				send_byte(some_byte(), 1'b1);
				return;
			end
			send_byte(some_byte(), 1'b0);
		end
	endtask

	initial begin
		int unsigned goal;
		int unsigned n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 5; i++)
			send_byte(PRE_MARK_BYTES[i], 1'b0);
		reconfigure(3, 2);
		for (int i = 0; i < 19; i++)
			send_byte(IMAGE_BYTES[i], i == 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < FIXED_PHASES)
				reconfigure(PHASE_W[p], PHASE_H[p]);
			else
				reconfigure(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 20)));
			goal = sent_bytes + PHASE_ITEMS;
			n = 0;
			while (sent_bytes < goal) begin
				if (n % 6 == 0)
					set_pace(pace_t'((n / 6 + p) % 4));
				if (n == 10)
					settle(0);
				send_packet((n == 0 && p != MID_IMAGE_PHASE) ||
					(n > 2 && $urandom_range(15) == 0));
				n++;
			end
		end

		settle(DRAIN_CYCLES);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
